### rtl/core/nc1q_pkg.sv
// ----------------------------------------------------------------------------
// nc1q_pkg
// Shared types and constants for the NHWC to NC1HWC2 quantizing transform.
// ----------------------------------------------------------------------------
`default_nettype none

package nc1q_pkg;

  localparam int SAMPLE_W   = 32;
  localparam int ADDR_OUT_W = 24;
  localparam int DATA_W     = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;
  localparam int CFG_DIM_W  = 13;
  localparam int BLK_W      = 6;
  localparam int CIB_W      = 5;
  localparam int BATCH_W    = 8;
  localparam int MODE_W     = 2;
  localparam int ZP_W       = 8;
  localparam int INV_W      = 24;
  localparam int MAX_BLOCK  = 32;

  localparam int FRAC_SHIFT = 32;
  localparam int QP_W       = SAMPLE_W + INV_W;
  localparam int QM_W       = QP_W + 1 - FRAC_SHIFT;
  localparam int QS_W       = QM_W + 2;
  localparam int Q_MIN      = -128;
  localparam int Q_MAX      = 127;

  typedef enum logic [MODE_W-1:0] {
    MODE_RAW    = 2'd0,
    MODE_QUANT  = 2'd1,
    MODE_OFFSET = 2'd2
  } mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HEIGHT         = 3'd0,
    REG_WIDTH          = 3'd1,
    REG_CHANNELS       = 3'd2,
    REG_BLOCK_CHANNELS = 3'd3,
    REG_PADDED_WIDTH   = 3'd4,
    REG_MODE           = 3'd5,
    REG_ZERO_POINT     = 3'd6,
    REG_INV_SCALE      = 3'd7
  } cfg_reg_t;

  typedef enum logic [1:0] {
    STEP_BLOCK = 2'd0,
    STEP_ROW   = 2'd1,
    STEP_COL   = 2'd2,
    STEP_LANE  = 2'd3
  } mac_step_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_MUL,
    ST_ADD,
    ST_LOAD
  } state_t;

  typedef struct packed {
    logic      div_init;
    logic      div_step;
    logic      capture;
    logic      mul;
    logic      add;
    logic      load;
    mac_step_t step;
  } cmd_t;

  typedef struct packed {
    logic stale;
    logic div_last;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

### rtl/core/nc1q_ctrl.sv
// ----------------------------------------------------------------------------
// nc1q_ctrl
// Sequencer: block-count division, four multiply-add address steps, load.
// ----------------------------------------------------------------------------
`default_nettype none

module nc1q_ctrl (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               in_valid,
  output logic              in_ready,
  input  nc1q_pkg::sts_t    sts,
  output nc1q_pkg::cmd_t    cmd
);
  import nc1q_pkg::*;

  state_t    state_r, state_nxt;
  mac_step_t step_r, step_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      step_r  <= STEP_BLOCK;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    step_nxt     = step_r;
    in_ready     = 1'b0;
    cmd          = '0;
    cmd.step     = step_r;
    case (state_r)
      ST_IDLE: begin
        in_ready = !sts.stale;
        if (sts.stale) begin
          cmd.div_init = 1'b1;
          state_nxt    = ST_DIV;
        end else if (in_valid) begin
          cmd.capture = 1'b1;
          step_nxt    = STEP_BLOCK;
          state_nxt   = ST_MUL;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = ST_ADD;
      end
      ST_ADD: begin
        cmd.add = 1'b1;
        case (step_r)
          STEP_BLOCK: begin
            step_nxt  = STEP_ROW;
            state_nxt = ST_MUL;
          end
          STEP_ROW: begin
            step_nxt  = STEP_COL;
            state_nxt = ST_MUL;
          end
          STEP_COL: begin
            step_nxt  = STEP_LANE;
            state_nxt = ST_MUL;
          end
          default: begin
            state_nxt = ST_LOAD;
          end
        endcase
      end
      ST_LOAD: begin
        if (sts.out_free) begin
          cmd.load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

### rtl/core/nc1q_dp.sv
// ----------------------------------------------------------------------------
// nc1q_dp
// Datapath: registers, position counters, block-count divider, address
// multiply-add unit, quantizer and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module nc1q_dp #(
  parameter int ADDR_BITS     = 24,
  parameter int DIM_BITS      = 12,
  parameter int DEFAULT_BLOCK = 16
) (
  input  wire                                     clk,
  input  wire                                     rst_n,
  input  nc1q_pkg::cmd_t                          cmd,
  output nc1q_pkg::sts_t                          sts,
  input  wire signed [nc1q_pkg::SAMPLE_W-1:0]     in_sample,
  input  wire                                     in_final_req,
  output logic                                    out_valid,
  input  wire                                     out_ready,
  output logic [nc1q_pkg::ADDR_OUT_W-1:0]         out_address,
  output logic [nc1q_pkg::DATA_W-1:0]             out_data_byte,
  output logic                                    out_addr_overflow,
  output logic                                    out_final_out,
  input  wire                                     cfg_we,
  input  wire  [nc1q_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  wire  [nc1q_pkg::CFG_DATA_W-1:0]         cfg_data
);
  import nc1q_pkg::*;

  localparam int EW  = (DIM_BITS + 1 > CFG_DIM_W) ? DIM_BITS + 1 : CFG_DIM_W;
  localparam int NW  = DIM_BITS + 1;
  localparam int DCW = $clog2(NW);
  localparam int PW  = ADDR_BITS + EW;

  // configuration
  logic [CFG_DIM_W-1:0]  height_r, width_r, channels_r, padded_width_r;
  logic [BLK_W-1:0]      block_channels_r;
  logic [MODE_W-1:0]     mode_r;
  logic signed [ZP_W-1:0] zero_point_r;
  logic [INV_W-1:0]      inv_scale_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      height_r         <= CFG_DIM_W'(1);
      width_r          <= CFG_DIM_W'(1);
      channels_r       <= CFG_DIM_W'(1);
      block_channels_r <= BLK_W'(16);
      padded_width_r   <= CFG_DIM_W'(1);
      mode_r           <= MODE_RAW;
      zero_point_r     <= '0;
      inv_scale_r      <= INV_W'(65536);
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_HEIGHT:         height_r         <= cfg_data[CFG_DIM_W-1:0];
        REG_WIDTH:          width_r          <= cfg_data[CFG_DIM_W-1:0];
        REG_CHANNELS:       channels_r       <= cfg_data[CFG_DIM_W-1:0];
        REG_BLOCK_CHANNELS: block_channels_r <= cfg_data[BLK_W-1:0];
        REG_PADDED_WIDTH:   padded_width_r   <= cfg_data[CFG_DIM_W-1:0];
        REG_MODE:           mode_r           <= cfg_data[MODE_W-1:0];
        REG_ZERO_POINT:     zero_point_r     <= cfg_data[ZP_W-1:0];
        REG_INV_SCALE:      inv_scale_r      <= cfg_data[INV_W-1:0];
        default: ;
      endcase
    end
  end

  function automatic logic [EW-1:0] eff_dim(input logic [CFG_DIM_W-1:0] v);
    logic [EW-1:0] ve;
    logic [EW-1:0] lim;
    ve  = EW'(v);
    lim = EW'(1) << DIM_BITS;
    if (v == '0) begin
      return EW'(1);
    end else if (ve > lim) begin
      return lim;
    end else begin
      return ve;
    end
  endfunction

  logic [EW-1:0]    h_eff, w_eff, c_eff, wp_eff;
  logic [BLK_W-1:0] c2_eff;

  always_comb begin
    h_eff  = eff_dim(height_r);
    w_eff  = eff_dim(width_r);
    c_eff  = eff_dim(channels_r);
    wp_eff = (EW'(padded_width_r) < w_eff) ? w_eff : EW'(padded_width_r);
    if (block_channels_r == '0) begin
      c2_eff = BLK_W'(DEFAULT_BLOCK);
    end else if (block_channels_r > BLK_W'(MAX_BLOCK)) begin
      c2_eff = BLK_W'(MAX_BLOCK);
    end else begin
      c2_eff = block_channels_r;
    end
  end

  // block count ceil(C / c2), restoring division one bit per cycle
  logic             stale_r;
  logic [NW-1:0]    divq_r;
  logic [BLK_W-1:0] divr_r, divs_r;
  logic [DCW-1:0]   divc_r;
  logic [EW:0]      div_num;
  logic [BLK_W:0]   div_sh;

  assign div_num = {1'b0, c_eff} + (EW + 1)'(c2_eff) - (EW + 1)'(1);
  assign div_sh  = {divr_r, divq_r[NW-1]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stale_r <= 1'b0;
      divq_r  <= NW'(1);
    end else begin
      if (cmd.div_init) begin
        stale_r <= 1'b0;
        divq_r  <= div_num[NW-1:0];
      end else if (cmd.div_step) begin
        divq_r  <= {divq_r[NW-2:0], (div_sh >= {1'b0, divs_r})};
      end
      if (cfg_we && (cfg_index inside {REG_CHANNELS, REG_BLOCK_CHANNELS})) begin
        stale_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      divr_r <= '0;
      divs_r <= c2_eff;
      divc_r <= DCW'(NW - 1);
    end else if (cmd.div_step) begin
      divr_r <= (div_sh >= {1'b0, divs_r}) ? BLK_W'(div_sh - {1'b0, divs_r})
                                           : div_sh[BLK_W-1:0];
      divc_r <= divc_r - DCW'(1);
    end
  end

  // position counters
  logic [BATCH_W-1:0]  batch_r, batch_nxt;
  logic [DIM_BITS-1:0] row_r, row_nxt, col_r, col_nxt;
  logic [DIM_BITS-1:0] chan_r, chan_nxt, cblk_r, cblk_nxt;
  logic [CIB_W-1:0]    cib_r, cib_nxt;

  logic signed [SAMPLE_W-1:0] sample_r;
  logic [SAMPLE_W-1:0]        mag_r;
  logic                       fin_r;

  always_comb begin
    batch_nxt = batch_r;
    row_nxt   = row_r;
    col_nxt   = col_r;
    chan_nxt  = chan_r + DIM_BITS'(1);
    cib_nxt   = cib_r + CIB_W'(1);
    cblk_nxt  = cblk_r;
    if (({1'b0, cib_nxt} >= c2_eff) || (cib_nxt == '0)) begin
      cib_nxt  = '0;
      cblk_nxt = cblk_r + DIM_BITS'(1);
    end
    if ((EW'(chan_nxt) >= c_eff) || (chan_nxt == '0)) begin
      chan_nxt = '0;
      cblk_nxt = '0;
      cib_nxt  = '0;
      col_nxt  = col_r + DIM_BITS'(1);
      if ((EW'(col_nxt) >= w_eff) || (col_nxt == '0)) begin
        col_nxt = '0;
        row_nxt = row_r + DIM_BITS'(1);
        if ((EW'(row_nxt) >= h_eff) || (row_nxt == '0)) begin
          row_nxt   = '0;
          batch_nxt = batch_r + BATCH_W'(1);
        end
      end
    end
    if (fin_r) begin
      batch_nxt = '0;
      row_nxt   = '0;
      col_nxt   = '0;
      chan_nxt  = '0;
      cblk_nxt  = '0;
      cib_nxt   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      batch_r <= '0;
      row_r   <= '0;
      col_r   <= '0;
      chan_r  <= '0;
      cblk_r  <= '0;
      cib_r   <= '0;
    end else if (cmd.load) begin
      batch_r <= batch_nxt;
      row_r   <= row_nxt;
      col_r   <= col_nxt;
      chan_r  <= chan_nxt;
      cblk_r  <= cblk_nxt;
      cib_r   <= cib_nxt;
    end
  end

  // address: acc = acc * m + a over four steps, low bits plus a sticky high flag
  logic [ADDR_BITS-1:0] acc_r;
  logic                 big_r, pbig_r;
  logic [PW-1:0]        prod_r;
  logic [EW-1:0]        mac_m;
  logic [ADDR_BITS-1:0] mac_a;
  logic [ADDR_BITS:0]   mac_sum;
  logic [QP_W-1:0]      qprod_r;

  always_comb begin
    case (cmd.step)
      STEP_BLOCK: begin
        mac_m = EW'(divq_r);
        mac_a = ADDR_BITS'(cblk_r);
      end
      STEP_ROW: begin
        mac_m = h_eff;
        mac_a = ADDR_BITS'(row_r);
      end
      STEP_COL: begin
        mac_m = wp_eff;
        mac_a = ADDR_BITS'(col_r);
      end
      default: begin
        mac_m = EW'(c2_eff);
        mac_a = ADDR_BITS'(cib_r);
      end
    endcase
  end

  assign mac_sum = {1'b0, prod_r[ADDR_BITS-1:0]} + {1'b0, mac_a};

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      sample_r <= in_sample;
      mag_r    <= in_sample[SAMPLE_W-1] ? SAMPLE_W'(-in_sample) : in_sample;
      fin_r    <= in_final_req;
      acc_r    <= ADDR_BITS'(batch_r);
      big_r    <= 1'b0;
    end
    if (cmd.mul) begin
      prod_r  <= PW'(acc_r) * PW'(mac_m);
      pbig_r  <= big_r && (mac_m != '0);
      qprod_r <= QP_W'(mag_r) * QP_W'(inv_scale_r);
    end
    if (cmd.add) begin
      acc_r <= mac_sum[ADDR_BITS-1:0];
      big_r <= pbig_r || (prod_r[PW-1:ADDR_BITS] != '0) || mac_sum[ADDR_BITS];
    end
  end

  // output byte
  logic [QP_W:0]          q_rnd;
  logic [QM_W-1:0]        q_mag;
  logic signed [QS_W-1:0] q_val, q_sum;
  logic [DATA_W-1:0]      byte_nxt;

  always_comb begin
    q_rnd = {1'b0, qprod_r} + ((QP_W + 1)'(1) << (FRAC_SHIFT - 1));
    q_mag = q_rnd[QP_W:FRAC_SHIFT];
    q_val = sample_r[SAMPLE_W-1] ? -$signed({2'b00, q_mag}) : $signed({2'b00, q_mag});
    q_sum = q_val + QS_W'(zero_point_r);
    if (q_sum < QS_W'(Q_MIN)) begin
      q_sum = QS_W'(Q_MIN);
    end else if (q_sum > QS_W'(Q_MAX)) begin
      q_sum = QS_W'(Q_MAX);
    end
    case (mode_r)
      MODE_QUANT:  byte_nxt = q_sum[DATA_W-1:0];
      MODE_OFFSET: byte_nxt = sample_r[DATA_W-1:0] + zero_point_r;
      default:     byte_nxt = sample_r[DATA_W-1:0];
    endcase
  end

  logic out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      out_address       <= ADDR_OUT_W'(acc_r);
      out_data_byte     <= byte_nxt;
      out_addr_overflow <= big_r;
      out_final_out     <= fin_r;
    end
  end

  assign out_valid    = out_valid_r;
  assign sts.stale    = stale_r;
  assign sts.div_last = (divc_r == '0);
  assign sts.out_free = !out_valid_r || out_ready;

endmodule

`default_nettype wire

### rtl/core/nhwc_to_nc1hwc2_quantize.sv
// ----------------------------------------------------------------------------
// nhwc_to_nc1hwc2_quantize
// NHWC element stream to NC1HWC2 byte address and int8 data byte.
//
//   channel  direction  handshake              payload
//   in_      in         in_valid / in_ready    in_sample, in_final_req
//   out_     out        out_valid / out_ready  out_address, out_data_byte,
//                                              out_addr_overflow, out_final_out
//   cfg_     in         cfg_valid / cfg_ready  cfg_index, cfg_data
//
// Each element passes through accept, four multiply then add steps of the
// shared address unit, and output load, before the next one is accepted.
// A write to channels or block_channels holds off the next accept while
// the block count is divided out one bit per cycle.
// Reset loads the register defaults and clears the position counters.
// A stalled result holds the load step; the address unit is then idle.
// ----------------------------------------------------------------------------
`default_nettype none

module nhwc_to_nc1hwc2_quantize #(
  parameter int ADDR_BITS     = 24,
  parameter int DIM_BITS      = 12,
  parameter int DEFAULT_BLOCK = 16
) (
  input  wire                                  clk,
  input  wire                                  rst_n,
  input  wire                                  in_valid,
  output logic                                 in_ready,
  input  wire signed [nc1q_pkg::SAMPLE_W-1:0]  in_sample,
  input  wire                                  in_final_req,
  output logic                                 out_valid,
  input  wire                                  out_ready,
  output logic [nc1q_pkg::ADDR_OUT_W-1:0]      out_address,
  output logic [nc1q_pkg::DATA_W-1:0]          out_data_byte,
  output logic                                 out_addr_overflow,
  output logic                                 out_final_out,
  input  wire                                  cfg_valid,
  output logic                                 cfg_ready,
  input  wire  [nc1q_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire  [nc1q_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import nc1q_pkg::*;

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = 1'b1;

  nc1q_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  nc1q_dp #(
    .ADDR_BITS     (ADDR_BITS),
    .DIM_BITS      (DIM_BITS),
    .DEFAULT_BLOCK (DEFAULT_BLOCK)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .in_sample         (in_sample),
    .in_final_req      (in_final_req),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_address       (out_address),
    .out_data_byte     (out_data_byte),
    .out_addr_overflow (out_addr_overflow),
    .out_final_out     (out_final_out),
    .cfg_we            (cfg_valid && cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

endmodule

`default_nettype wire

### rtl/core/nc1q_chk.sv
// ----------------------------------------------------------------------------
// nc1q_chk
// Port-level checks for nhwc_to_nc1hwc2_quantize, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module nc1q_chk (
  input wire        clk,
  input wire        rst_n,
  input wire        in_valid,
  input wire        in_ready,
  input wire        out_valid,
  input wire        out_ready,
  input wire [23:0] out_address,
  input wire [7:0]  out_data_byte,
  input wire        out_addr_overflow,
  input wire        out_final_out
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_address) &&
      $stable(out_data_byte) && $stable(out_addr_overflow) && $stable(out_final_out))
    else $error("stalled result transaction changed");

  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready ##1 !in_ready ##1 !in_ready)
    else $error("input transaction accepted while busy");

  a_no_result_early: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && !out_valid |=> !out_valid ##1 !out_valid)
    else $error("result transaction without finished work");

endmodule

bind nhwc_to_nc1hwc2_quantize nc1q_chk u_chk (.*);

`default_nettype wire

### tb/tb_nhwc_to_nc1hwc2_quantize.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_nhwc_to_nc1hwc2_quantize
// Self-checking bench for the NHWC to NC1HWC2 quantizing transform. A layout
// and int8 quantization model inside the bench predicts address, byte,
// overflow flag and final mark for every accepted element. Results are checked
// in order while the sender bursts and the receiver stalls at random.
// ----------------------------------------------------------------------------

module tb_nhwc_to_nc1hwc2_quantize;
  import nc1q_pkg::*;

  localparam int          DIM_LIMIT     = 4096;
  localparam int          DEFAULT_BLOCK = 16;
  localparam logic [1:0]  MODE_UNUSED   = 2'd3;

  typedef struct {
    logic [23:0] address;
    logic [7:0]  data_byte;
    logic        overflow;
    logic        final_mark;
  } placement_t;

  logic                  clk               = 1'b0;
  logic                  rst_n             = 1'b0;
  logic                  in_valid          = 1'b0;
  logic                  in_ready;
  logic [SAMPLE_W-1:0]   in_sample         = '0;
  logic                  in_final_req      = 1'b0;
  logic                  out_valid;
  logic                  out_ready         = 1'b0;
  logic [ADDR_OUT_W-1:0] out_address;
  logic [DATA_W-1:0]     out_data_byte;
  logic                  out_addr_overflow;
  logic                  out_final_out;
  logic                  cfg_valid         = 1'b0;
  logic                  cfg_ready;
  cfg_reg_t              cfg_index         = REG_HEIGHT;
  logic [CFG_DATA_W-1:0] cfg_data          = '0;

  // layout model state
  logic [12:0] reg_height    = 13'd1;
  logic [12:0] reg_width     = 13'd1;
  logic [12:0] reg_channels  = 13'd1;
  logic [5:0]  reg_block     = 6'd16;
  logic [12:0] reg_pad       = 13'd1;
  logic [1:0]  reg_mode      = MODE_RAW;
  logic [7:0]  reg_zp        = 8'd0;
  logic [23:0] reg_inv_scale = 24'd65536;
  logic [7:0]  at_batch      = '0;
  logic [11:0] at_row        = '0;
  logic [11:0] at_col        = '0;
  logic [11:0] at_chan       = '0;
  logic [11:0] at_blk        = '0;
  logic [4:0]  at_lane       = '0;

  placement_t  placement_q[$];
  placement_t  head;
  int          fault_count   = 0;
  int          burst_left    = 0;
  bit          valid_held    = 1'b0;
  logic [5:0]  stall_tick    = '0;
  int          stall_style   = 0;

  nhwc_to_nc1hwc2_quantize u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_sample         (in_sample),
    .in_final_req      (in_final_req),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_address       (out_address),
    .out_data_byte     (out_data_byte),
    .out_addr_overflow (out_addr_overflow),
    .out_final_out     (out_final_out),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  always #10 clk = ~clk;

  function automatic logic [63:0] eff_dim(input logic [12:0] v);
    if (v == 0) return 64'd1;
    return (v > DIM_LIMIT) ? 64'(DIM_LIMIT) : 64'(v);
  endfunction

  // Place one element, make its byte, then advance or reset the NHWC position.
  function automatic placement_t place_element(input logic [31:0] smp, input logic fin);
    placement_t         res;
    logic [63:0]        h, w, c, c2, wp, c1n, addr, mag, prod, rnd;
    logic signed [63:0] q;
    h = eff_dim(reg_height);
    w = eff_dim(reg_width);
    c = eff_dim(reg_channels);
    if (reg_block == 0) c2 = DEFAULT_BLOCK;
    else if (reg_block > MAX_BLOCK) c2 = MAX_BLOCK;
    else c2 = reg_block;
    wp = (reg_pad < w) ? w : 64'(reg_pad);
    c1n = (c + c2 - 1) / c2;
    addr = ((64'(at_batch) * c1n + at_blk) * h + at_row) * wp * c2 + 64'(at_col) * c2 + at_lane;
    res.address = addr[23:0];
    res.overflow = (addr > 64'hFF_FFFF);
    res.final_mark = fin;
    case (reg_mode)
      MODE_QUANT: begin
        mag = smp[31] ? {32'd0, -smp} : {32'd0, smp};
        prod = mag * reg_inv_scale;
        rnd = (prod + 64'h8000_0000) >> 32;
        q = smp[31] ? -$signed(rnd) : $signed(rnd);
        q = q + $signed(reg_zp);
        if (q < Q_MIN) q = Q_MIN;
        if (q > Q_MAX) q = Q_MAX;
        res.data_byte = q[7:0];
      end
      MODE_OFFSET: res.data_byte = smp[7:0] + reg_zp;
      default: res.data_byte = smp[7:0];
    endcase
    if (fin) begin
      at_batch = '0; at_row = '0; at_col = '0;
      at_chan = '0; at_blk = '0; at_lane = '0;
    end else begin
      at_chan = at_chan + 1'b1;
      at_lane = at_lane + 1'b1;
      if (at_lane >= c2 || at_lane == 0) begin
        at_lane = '0;
        at_blk = at_blk + 1'b1;
      end
      if (at_chan >= c || at_chan == 0) begin
        at_chan = '0; at_blk = '0; at_lane = '0;
        at_col = at_col + 1'b1;
        if (at_col >= w || at_col == 0) begin
          at_col = '0;
          at_row = at_row + 1'b1;
          if (at_row >= h || at_row == 0) begin
            at_row = '0;
            at_batch = at_batch + 1'b1;
          end
        end
      end
    end
    return res;
  endfunction

  function automatic logic [12:0] pick_dim(input int top);
    case ($urandom_range(0, 11))
      0:       return 13'd0;
      1:       return 13'($urandom_range(4096, 8191));
      default: return 13'($urandom_range(1, top));
    endcase
  endfunction

  function automatic logic [5:0] pick_block();
    case ($urandom_range(0, 7))
      0:       return 6'd0;
      1:       return 6'($urandom_range(33, 63));
      2:       return 6'd32;
      default: return 6'($urandom_range(1, 16));
    endcase
  endfunction

  function automatic logic [12:0] pick_pad(input logic [12:0] w);
    case ($urandom_range(0, 5))
      0:       return 13'd0;
      1:       return 13'($urandom_range(0, 8191));
      default: return w + 13'($urandom_range(0, 3));
    endcase
  endfunction

  function automatic logic [1:0] pick_mode();
    case ($urandom_range(0, 7))
      0:       return MODE_RAW;
      1:       return MODE_OFFSET;
      2:       return MODE_UNUSED;
      default: return MODE_QUANT;
    endcase
  endfunction

  function automatic logic [23:0] pick_inv();
    case ($urandom_range(0, 7))
      0:       return 24'd0;
      1:       return 24'hFF_FFFF;
      2:       return 24'($urandom);
      3, 4:    return 24'd65536;
      default: return 24'($urandom_range(4096, 1 << 20));
    endcase
  endfunction

  function automatic logic [31:0] pick_sample();
    logic [31:0] t;
    case ($urandom_range(0, 4))
      0: t = $urandom;
      1: t = 32'($urandom_range(0, 32'h00FF_FFFF)) - 32'h0080_0000;
      2: t = ((32'($urandom_range(0, 511)) - 32'd256) << 16) | 32'h0000_8000;
      3: begin
        case ($urandom_range(0, 3))
          0:       t = 32'h7FFF_FFFF;
          1:       t = 32'h8000_0000;
          2:       t = 32'h0000_0000;
          default: t = 32'hFFFF_FFFF;
        endcase
      end
      default: t = 32'($urandom_range(0, 32'h0003_FFFF)) - 32'h0002_0000;
    endcase
    return t;
  endfunction

  task automatic wait_drained();
    if (valid_held) begin
      in_valid <= 1'b0;
      valid_held = 1'b0;
    end
    burst_left = 0;
    while (placement_q.size() != 0) @(posedge clk);
  endtask

  task automatic send_element(input logic [31:0] smp, input logic fin);
    if (burst_left == 0) begin
      if (valid_held) begin
        in_valid <= 1'b0;
        valid_held = 1'b0;
      end
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 8);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_sample <= smp;
    in_final_req <= fin;
    valid_held = 1'b1;
    do @(posedge clk); while (!in_ready);
    placement_q.push_back(place_element(smp, fin));
  endtask

  // Drain, then write all registers in index order.
  task automatic apply_cfg(input logic [12:0] h, input logic [12:0] w, input logic [12:0] c,
                           input logic [5:0] blk, input logic [12:0] wp, input logic [1:0] md,
                           input logic [7:0] zp, input logic [23:0] inv);
    logic [23:0] vals [8];
    cfg_reg_t    idx;
    wait_drained();
    vals = '{h, w, c, blk, wp, md, zp, inv};
    for (int i = 0; i < 8; i++) begin
      idx = cfg_reg_t'(i);
      cfg_valid <= 1'b1;
      cfg_index <= idx;
      cfg_data <= vals[i];
      do @(posedge clk); while (!cfg_ready);
      case (idx)
        REG_HEIGHT:         reg_height = vals[i][12:0];
        REG_WIDTH:          reg_width = vals[i][12:0];
        REG_CHANNELS:       reg_channels = vals[i][12:0];
        REG_BLOCK_CHANNELS: reg_block = vals[i][5:0];
        REG_PADDED_WIDTH:   reg_pad = vals[i][12:0];
        REG_MODE:           reg_mode = vals[i][1:0];
        REG_ZERO_POINT:     reg_zp = vals[i][7:0];
        default:            reg_inv_scale = vals[i][23:0];
      endcase
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic test_reset_defaults();
    send_element(32'h7FFF_FFFF, 1'b0);
    send_element(32'h8000_0000, 1'b0);
    send_element(32'h0000_00FF, 1'b1);
  endtask

  task automatic test_quantize_rounding();
    apply_cfg(1, 1, 1, 16, 1, MODE_QUANT, 8'h00, 24'd65536);
    send_element(32'h0000_8000, 1'b0);
    send_element(32'hFFFF_8000, 1'b0);
    send_element(32'h0000_7FFF, 1'b1);
    apply_cfg(1, 1, 1, 16, 1, MODE_QUANT, 8'h7F, 24'hFF_FFFF);
    send_element(32'h8000_0000, 1'b0);
    send_element(32'h7FFF_FFFF, 1'b1);
    apply_cfg(1, 1, 1, 16, 1, MODE_QUANT, 8'h80, 24'd0);
    send_element(32'h1234_5678, 1'b1);
  endtask

  task automatic test_byte_modes();
    apply_cfg(1, 1, 1, 16, 1, MODE_OFFSET, 8'hFF, 24'd65536);
    send_element(32'hAAAA_AA80, 1'b1);
    apply_cfg(1, 1, 1, 16, 1, MODE_UNUSED, 8'h55, 24'd65536);
    send_element(32'h5555_557F, 1'b1);
  endtask

  task automatic test_dimension_clamps();
    apply_cfg(0, 0, 0, 0, 0, MODE_RAW, 8'h00, 24'd65536);
    send_element(32'h0000_0001, 1'b0);
    apply_cfg(8191, 8191, 8191, 63, 8191, MODE_RAW, 8'h00, 24'd65536);
    send_element(32'h0000_0002, 1'b1);
    apply_cfg(4096, 4096, 4096, 1, 8191, MODE_RAW, 8'h00, 24'd65536);
    send_element(32'h0000_0003, 1'b0);
    send_element(32'h0000_0004, 1'b1);
    apply_cfg(2, 3, 1, 4, 1, MODE_RAW, 8'h00, 24'd65536);
    send_element(32'h0000_0005, 1'b0);
    send_element(32'h0000_0006, 1'b1);
  endtask

  // Shrink dimensions with the position counters past the new limits.
  task automatic test_counter_rollover();
    apply_cfg(2, 4, 1, 16, 4, MODE_RAW, 8'h00, 24'd65536);
    repeat (3) send_element($urandom, 1'b0);
    apply_cfg(2, 2, 1, 16, 4, MODE_RAW, 8'h00, 24'd65536);
    send_element($urandom, 1'b0);
    send_element($urandom, 1'b1);
    apply_cfg(1, 1, 10, 4, 1, MODE_RAW, 8'h00, 24'd65536);
    repeat (6) send_element($urandom, 1'b0);
    apply_cfg(1, 1, 3, 2, 1, MODE_RAW, 8'h00, 24'd65536);
    send_element($urandom, 1'b0);
    send_element($urandom, 1'b1);
  endtask

  task automatic test_random_tensors(input int target);
    int          sent;
    int          n;
    int          pause_at;
    int          kind;
    longint      image;
    logic [12:0] h, w, c;
    logic        fin;
    sent = 0;
    while (sent < target) begin
      kind = $urandom_range(0, 9);
      h = pick_dim(3);
      w = pick_dim(4);
      c = pick_dim(24);
      apply_cfg(h, w, c, pick_block(), pick_pad(w), pick_mode(), 8'($urandom), pick_inv());
      image = eff_dim(h) * eff_dim(w) * eff_dim(c) * $urandom_range(1, 2);
      if (kind >= 8) n = $urandom_range(1, 40);
      else n = (image > 96) ? $urandom_range(8, 96) : int'(image);
      pause_at = ($urandom_range(0, 5) == 0) ? n / 2 : -1;
      for (int k = 0; k < n; k++) begin
        if (k == pause_at) wait_drained();
        fin = (kind < 8 && k == n - 1) || ($urandom_range(0, 63) == 0);
        send_element(pick_sample(), fin);
      end
      sent += n;
    end
  endtask

  // Unit image: every element advances the batch counter through its wrap.
  task automatic test_batch_wrap(input int n);
    apply_cfg(1, 1, 1, pick_block(), pick_pad(13'd1), pick_mode(), 8'($urandom), pick_inv());
    for (int k = 0; k < n; k++) begin
      if (k == n / 2) wait_drained();
      send_element(pick_sample(), k == n - 1);
    end
  endtask

  always @(posedge clk) begin
    stall_tick <= stall_tick + 1'b1;
    if (stall_tick == 0) stall_style <= $urandom_range(0, 3);
    case (stall_style)
      0:       out_ready <= 1'b1;
      1:       out_ready <= ($urandom_range(0, 3) != 0);
      2:       out_ready <= (stall_tick[2:0] == 3'd0);
      default: out_ready <= $urandom_range(0, 1);
    endcase
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (placement_q.size() == 0) begin
        $error("unexpected transaction: address %0h data_byte %0h", out_address, out_data_byte);
        fault_count++;
      end else begin
        head = placement_q.pop_front();
        if (out_address !== head.address) begin
          $error("address: expected %0h, got %0h", head.address, out_address);
          fault_count++;
        end
        if (out_data_byte !== head.data_byte) begin
          $error("data_byte: expected %0h, got %0h", head.data_byte, out_data_byte);
          fault_count++;
        end
        if (out_addr_overflow !== head.overflow) begin
          $error("addr_overflow: expected %0b, got %0b", head.overflow, out_addr_overflow);
          fault_count++;
        end
        if (out_final_out !== head.final_mark) begin
          $error("final_out: expected %0b, got %0b", head.final_mark, out_final_out);
          fault_count++;
        end
      end
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_defaults();
    test_quantize_rounding();
    test_byte_modes();
    test_dimension_clamps();
    test_counter_rollover();
    test_random_tensors(560);
    test_batch_wrap(260);
    wait_drained();
    repeat (40) @(posedge clk);
    if (fault_count == 0) begin
      $display("tb_nhwc_to_nc1hwc2_quantize OK");
    end else begin
      $display("tb_nhwc_to_nc1hwc2_quantize NOT OK");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("timeout, %0d transactions outstanding", placement_q.size());
    $display("tb_nhwc_to_nc1hwc2_quantize NOT OK");
    $finish;
  end

endmodule
